// ----- hdl/bma_pkg.sv -----
// Package with the operation codes and flag types of the bit manipulation ALU.
`timescale 1ns / 1ps
`default_nettype none
package bma_pkg;

    // Operation codes carried in the low bits of the input tuser.
    typedef enum logic [3:0] {
        KIND_ANDN   = 4'd0,
        KIND_BEXTR  = 4'd1,
        KIND_BLSI   = 4'd2,
        KIND_BLSMSK = 4'd3,
        KIND_BLSR   = 4'd4,
        KIND_BZHI   = 4'd5,
        KIND_MULX   = 4'd6,
        KIND_PDEP   = 4'd7,
        KIND_PEXT   = 4'd8,
        KIND_RORX   = 4'd9,
        KIND_SARX   = 4'd10,
        KIND_SHLX   = 4'd11,
        KIND_SHRX   = 4'd12
    } kind_t;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned HALF_W = 32;

    // Flag write group; OF and AF are always written as zero.
    typedef struct packed {
        logic upd;
        logic sf;
        logic zf;
        logic cf;
        logic pf;
    } flags_t;

endpackage
`default_nettype wire

// ----- hdl/bma_mul.sv -----
// 64 by 64 multiplier built from four registered 32 by 32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module bma_mul (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [63:0]  op_a,
    input  wire logic [63:0]  op_b,
    output logic      [127:0] product
);
    import bma_pkg::*;

    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;

    // Partial products, one multiplier each, registered.
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg <= op_a[HALF_W-1:0] * op_b[HALF_W-1:0];
            p01_reg <= op_a[HALF_W-1:0] * op_b[DATA_W-1:HALF_W];
            p10_reg <= op_a[DATA_W-1:HALF_W] * op_b[HALF_W-1:0];
            p11_reg <= op_a[DATA_W-1:HALF_W] * op_b[DATA_W-1:HALF_W];
        end
    end

    // Sum of the aligned partial products.
    assign product = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                   + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};

endmodule
`default_nettype wire

// ----- hdl/bma_bitperm.sv -----
// Byte-sliced PDEP and PEXT unit with a registered offset stage.
`timescale 1ns / 1ps
`default_nettype none
module bma_bitperm (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] src,
    input  wire logic [63:0] mask,
    output logic      [63:0] pdep_res,
    output logic      [63:0] pext_res
);
    import bma_pkg::*;

    localparam int unsigned NB = DATA_W / 8;

    logic [63:0]      src_reg, mask_reg;
    logic [6:0]       off_reg [NB];
    logic [7:0]       ext_reg [NB];
    logic [6:0]       off_next [NB];
    logic [7:0]       ext_next [NB];

    // Gather the mask-selected bits of one byte into its low bits.
    function automatic logic [7:0] ext8(input logic [7:0] s, input logic [7:0] m);
        logic [7:0] r;
        logic [3:0] k;
        r = 8'd0;
        k = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (m[i]) begin
                r[k[2:0]] = s[i];
                k = k + 4'd1;
            end
        end
        return r;
    endfunction

    // Scatter the low bits of s into the set positions of one mask byte.
    function automatic logic [7:0] dep8(input logic [7:0] s, input logic [7:0] m);
        logic [7:0] r;
        logic [3:0] k;
        r = 8'd0;
        k = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (m[i]) begin
                r[i] = s[k[2:0]];
                k = k + 4'd1;
            end
        end
        return r;
    endfunction

    // Per-byte gathered bits and the running count of mask bits below each byte.
    always_comb begin
        logic [6:0] acc;
        acc = 7'd0;
        for (int j = 0; j < NB; j++) begin
            off_next[j] = acc;
            ext_next[j] = ext8(src[8*j +: 8], mask[8*j +: 8]);
            acc = acc + 7'($countones(mask[8*j +: 8]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            src_reg  <= src;
            mask_reg <= mask;
            for (int j = 0; j < NB; j++) begin
                off_reg[j] <= off_next[j];
                ext_reg[j] <= ext_next[j];
            end
        end
    end

    // Combine the byte slices using the registered offsets.
    always_comb begin
        logic [63:0] sh;
        pext_res = 64'd0;
        pdep_res = 64'd0;
        for (int j = 0; j < NB; j++) begin
            pext_res = pext_res | ({56'd0, ext_reg[j]} << off_reg[j]);
            sh = src_reg >> off_reg[j];
            pdep_res[8*j +: 8] = dep8(sh[7:0], mask_reg[8*j +: 8]);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bit_manipulation_alu.sv -----
// Top level of the BMI1/BMI2 bit manipulation ALU.
//
//  channel | dir | tdata                                        | tuser
//  s_      | in  | first_operand, second_operand, rdx, rot count | kind, wide
//  m_      | out | result_low, result_high, flags               | -
//
// One item per cycle while the result side does not stall.
// Stage one registers the masked operands, stage two holds the simple
// operations, the partial products and the PDEP/PEXT offsets, stage three
// is the output register. A stall on the result side freezes all stages.
// Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module bit_manipulation_alu (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_operand[63:0], second_operand[127:64], rdx_value[191:128],
    // rotate_count[199:192]
    input  wire logic [199:0] s_tdata,
    // kind[3:0], wide[4]
    input  wire logic [4:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_low[63:0], result_high[127:64], flags_update[128], flag_sf[129],
    // flag_zf[130], flag_cf[131], flag_of[132], flag_af[133], flag_pf[134], zero[135]
    output logic      [135:0] m_tdata
);
    import bma_pkg::*;

    logic        en;
    logic        v1_reg, v2_reg, v3_reg;
    kind_t       kind1_reg, kind2_reg, kind3_reg;
    logic        wide1_reg, wide2_reg, wide3_reg;
    logic [63:0] a1_reg, b1_reg, d1_reg;
    logic [5:0]  rc1_reg;
    logic [63:0] lo2_reg, lo2_next;
    flags_t      fl2_reg, fl2_next;
    logic [63:0] lo3_reg, hi3_reg, lo3_next, hi3_next;
    flags_t      fl3_reg;
    logic [63:0] wmask_in;
    logic [127:0] product;
    logic [63:0] pdep_res, pext_res;

    // The whole pipeline advances unless a held result is not taken.
    assign en       = !v3_reg || m_tready;
    assign s_tready = en;
    assign wmask_in = s_tuser[4] ? {64{1'b1}} : {32'd0, {32{1'b1}}};

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one: operands truncated to the operand width.
    always_ff @(posedge aclk) begin
        if (en) begin
            kind1_reg <= kind_t'(s_tuser[3:0]);
            wide1_reg <= s_tuser[4];
            a1_reg    <= s_tdata[63:0] & wmask_in;
            b1_reg    <= s_tdata[127:64] & wmask_in;
            d1_reg    <= s_tdata[191:128] & wmask_in;
            rc1_reg   <= s_tdata[197:192] & {s_tuser[4], 5'h1F};
        end
    end

    // Stage two: the simple operations and their flags.
    always_comb begin
        logic [63:0] wmask, r, msk;
        logic [7:0]  bits, start, len, n, bz;
        logic [8:0]  slen;
        logic [5:0]  c;
        logic        msb;
        wmask    = wide1_reg ? {64{1'b1}} : {32'd0, {32{1'b1}}};
        bits     = wide1_reg ? 8'd64 : 8'd32;
        c        = b1_reg[5:0] & {wide1_reg, 5'h1F};
        start    = b1_reg[7:0];
        len      = b1_reg[15:8];
        slen     = {1'b0, start} + {1'b0, len};
        bz       = b1_reg[7:0];
        r        = 64'd0;
        n        = 8'd0;
        msk      = 64'd0;
        fl2_next = '0;
        case (kind1_reg)
            KIND_ANDN: begin
                r = ~a1_reg & b1_reg & wmask;
                fl2_next.upd = 1'b1;
                fl2_next.pf  = ~(^r[7:0]);
            end
            KIND_BEXTR: begin
                if ({1'b0, start} < {1'b0, bits}) begin
                    n   = (slen >= {1'b0, bits}) ? bits - start : len;
                    msk = (n < 8'd64) ? ~({64{1'b1}} << n[5:0]) : {64{1'b1}};
                    r   = (a1_reg >> start[5:0]) & msk;
                end
                fl2_next.upd = 1'b1;
            end
            KIND_BLSI: begin
                r = a1_reg & (~a1_reg + 64'd1) & wmask;
                fl2_next.upd = 1'b1;
                fl2_next.cf  = (a1_reg != 64'd0);
            end
            KIND_BLSMSK: begin
                r = (a1_reg ^ (a1_reg - 64'd1)) & wmask;
                fl2_next.upd = 1'b1;
                fl2_next.cf  = (a1_reg == 64'd0);
            end
            KIND_BLSR: begin
                r = a1_reg & (a1_reg - 64'd1) & wmask;
                fl2_next.upd = 1'b1;
                fl2_next.cf  = (a1_reg == 64'd0);
            end
            KIND_BZHI: begin
                if (bz < bits) begin
                    r = a1_reg & ~({64{1'b1}} << bz[5:0]);
                end else begin
                    r = a1_reg;
                end
                fl2_next.upd = 1'b1;
                fl2_next.cf  = (bz >= bits);
            end
            KIND_RORX: begin
                if (wide1_reg) begin
                    r = (a1_reg >> rc1_reg) | (a1_reg << (7'd64 - {1'b0, rc1_reg}));
                end else begin
                    r = {32'd0, (a1_reg[31:0] >> rc1_reg[4:0])
                              | (a1_reg[31:0] << (6'd32 - {1'b0, rc1_reg[4:0]}))};
                end
            end
            KIND_SARX: begin
                if (wide1_reg) begin
                    r = $unsigned($signed(a1_reg) >>> c);
                end else begin
                    r = {32'd0, $unsigned($signed(a1_reg[31:0]) >>> c[4:0])};
                end
            end
            KIND_SHLX: r = (a1_reg << c) & wmask;
            KIND_SHRX: r = a1_reg >> c;
            default:   r = 64'd0;
        endcase
        // Sign and zero flags follow the result; BEXTR reports no sign, BLSMSK no zero.
        msb = wide1_reg ? r[63] : r[31];
        if (fl2_next.upd) begin
            fl2_next.sf = msb && (kind1_reg != KIND_BEXTR);
            fl2_next.zf = (r == 64'd0) && (kind1_reg != KIND_BLSMSK);
        end
        lo2_next = r;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind2_reg <= kind1_reg;
            wide2_reg <= wide1_reg;
            lo2_reg   <= lo2_next;
            fl2_reg   <= fl2_next;
        end
    end

    bma_mul u_mul (
        .aclk    (aclk),
        .en      (en),
        .op_a    (d1_reg),
        .op_b    (b1_reg),
        .product (product)
    );

    bma_bitperm u_bitperm (
        .aclk     (aclk),
        .en       (en),
        .src      (a1_reg),
        .mask     (b1_reg),
        .pdep_res (pdep_res),
        .pext_res (pext_res)
    );

    // Stage three: pick the finished result.
    always_comb begin
        lo3_next = lo2_reg;
        hi3_next = 64'd0;
        case (kind2_reg)
            KIND_MULX: begin
                if (wide2_reg) begin
                    lo3_next = product[63:0];
                    hi3_next = product[127:64];
                end else begin
                    lo3_next = {32'd0, product[31:0]};
                    hi3_next = {32'd0, product[63:32]};
                end
            end
            KIND_PDEP: lo3_next = pdep_res;
            KIND_PEXT: lo3_next = pext_res;
            default:   lo3_next = lo2_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind3_reg <= kind2_reg;
            wide3_reg <= wide2_reg;
            lo3_reg   <= lo3_next;
            hi3_reg   <= hi3_next;
            fl3_reg   <= fl2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {1'b0, fl3_reg.pf, 1'b0, 1'b0, fl3_reg.cf, fl3_reg.zf, fl3_reg.sf,
                       fl3_reg.upd, hi3_reg, lo3_reg};

    // Flag values are zero whenever no flag write is signaled.
    a_flags_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !fl3_reg.upd) |-> !(fl3_reg.sf || fl3_reg.zf || fl3_reg.cf || fl3_reg.pf))
        else $error("flag value set without a flag write");

    // Only MULX produces a high half.
    a_high_mulx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && hi3_reg != 64'd0) |-> (kind3_reg == KIND_MULX))
        else $error("high result half set for an operation other than mulx");

    // Narrow operations leave the upper half of both results clear.
    a_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !wide3_reg) |-> (lo3_reg[63:32] == 32'd0 && hi3_reg[63:32] == 32'd0))
        else $error("32-bit result carries upper bits");

    // Flag writes come only from the flag-writing operations.
    a_upd_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && fl3_reg.upd) |-> (kind3_reg == KIND_ANDN || kind3_reg == KIND_BEXTR
            || kind3_reg == KIND_BLSI || kind3_reg == KIND_BLSMSK
            || kind3_reg == KIND_BLSR || kind3_reg == KIND_BZHI))
        else $error("flag write from an operation that writes no flags");

endmodule
`default_nettype wire
